@@ hdl/hzs_pkg.sv @@
// Shared constants for the heater zone supervisor: codes, register indexes, reset values.
package hzs_pkg;

  // Command codes carried in the opcode field
  localparam logic [1:0] OP_SAMPLE  = 2'd0;
  localparam logic [1:0] OP_ENABLE  = 2'd1;
  localparam logic [1:0] OP_DISABLE = 2'd2;
  localparam logic [1:0] OP_APPLY   = 2'd3;

  // Zone mode codes
  localparam logic [1:0] MODE_OFF     = 2'd0;
  localparam logic [1:0] MODE_STANDBY = 2'd1;
  localparam logic [1:0] MODE_MOVING  = 2'd2;
  localparam logic [1:0] MODE_READY   = 2'd3;

  // Configuration register indexes
  localparam logic [2:0] CFG_SETPOINT     = 3'd0;
  localparam logic [2:0] CFG_LOW_WARN     = 3'd1;
  localparam logic [2:0] CFG_LOW_OK       = 3'd2;
  localparam logic [2:0] CFG_HIGH_OK      = 3'd3;
  localparam logic [2:0] CFG_HIGH_WARN    = 3'd4;
  localparam logic [2:0] CFG_SAFETY_MAX   = 3'd5;
  localparam logic [2:0] CFG_SENSORS      = 3'd6;
  localparam logic [2:0] CFG_UNCONNECTED  = 3'd7;

  // Safety sensor count: supported sensors and sensor fields on the port
  localparam int SAFETY_SENSORS    = 4;
  localparam int NUM_SENSOR_FIELDS = 4;
  localparam int SENSOR_LIMIT      = (SAFETY_SENSORS < NUM_SENSOR_FIELDS) ?
                                     SAFETY_SENSORS : NUM_SENSOR_FIELDS;

  // Register reset values
  localparam logic [15:0] SAFETY_MAX_RESET   = 16'd10000;
  localparam logic [15:0] SAFETY_LOWER_RESET = 16'd9000;
  localparam logic [15:0] UNCONNECTED_RESET  = 16'hFFFF;

  // floor(x/10) = (x * RECIP_TENTH) >> RECIP_SHIFT, exact for x below 2^22
  localparam logic [19:0] RECIP_TENTH = 20'd838861;
  localparam int          RECIP_SHIFT = 23;

endpackage

@@ hdl/heater_zone_supervisor.sv @@
// Heater zone supervisor: command decode, temperature windows, over-temperature latch.

// Supervises one heater zone. Each input word carries a command (sample, enable,
// disable, apply set point) and yields exactly one result word. The block takes a
// new word every clock cycle while in_stall is low; a word enters an input
// register, its result is worked out in one pass of comparators and adders
// against the zone state, and it lands in the output register when it moves on
// from the input register. The flow is held only by the output side: in_stall
// rises when both the input and output registers are full and the output is
// stalled. The release level of the safety latch, floor(safety_max*9/10), is
// computed when safety_max is written, so register writes are never held off
// (cfg_ready is always high).
// Configuration is to be written only while no words are in flight.
module heater_zone_supervisor
  import hzs_pkg::*;
(
  input  logic               clk,
  input  logic               rst,

  // Configuration write channel
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,

  // Command channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         opcode,
  input  logic signed [15:0] zone_temp,
  input  logic [15:0]        pid_drive,
  input  logic [31:0]        seq_number,
  input  logic [15:0]        safety_temp_a,
  input  logic [15:0]        safety_temp_b,
  input  logic [15:0]        safety_temp_c,
  input  logic [15:0]        safety_temp_d,

  // Result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         zone_mode,
  output logic               power_valid,
  output logic [15:0]        output_power,
  output logic               temp_error,
  output logic               temp_warning,
  output logic               safety_error,
  output logic               seq_done,
  output logic [31:0]        done_seq_number,
  output logic               accepted
);

  // Configuration registers
  logic [14:0] setpoint_temp;
  logic [15:0] low_warn_offset;
  logic [15:0] low_ok_offset;
  logic [15:0] high_ok_offset;
  logic [15:0] high_warn_offset;
  logic [15:0] safety_max;
  logic [15:0] safety_lower;
  logic [2:0]  sensors_in_use;
  logic [15:0] unconnected_mark;

  // Zone state
  logic [1:0]         mode;
  logic signed [17:0] bound_low_warn;
  logic signed [17:0] bound_low_ok;
  logic signed [17:0] bound_high_ok;
  logic signed [17:0] bound_high_warn;
  logic [31:0]        stored_seq;
  logic               setpoint_applied;
  logic               safety_latched;
  logic               error_flag;
  logic               warning_flag;

  // Input register
  logic               in_full;
  logic [1:0]         item_opcode;
  logic signed [15:0] item_zone_temp;
  logic [15:0]        item_pid_drive;
  logic [31:0]        item_seq_number;
  logic [15:0]        item_sensor [NUM_SENSOR_FIELDS];

  // Next values
  logic [1:0]         mode_next;
  logic signed [17:0] bound_low_warn_next;
  logic signed [17:0] bound_low_ok_next;
  logic signed [17:0] bound_high_ok_next;
  logic signed [17:0] bound_high_warn_next;
  logic [31:0]        stored_seq_next;
  logic               setpoint_applied_next;
  logic               safety_latched_next;
  logic               error_flag_next;
  logic               warning_flag_next;
  logic               power_valid_next;
  logic [15:0]        output_power_next;
  logic               seq_done_next;
  logic [31:0]        done_seq_number_next;
  logic               accepted_next;

  logic               in_take;
  logic               advance;
  logic [2:0]         sensors_eff;
  logic               trip;
  logic               release_ok;
  logic [15:0]        sensor_val;
  logic signed [17:0] temp_ext;
  logic signed [17:0] setpoint_ext;
  logic               in_ok_window;
  logic               in_warn_window;

  // Release level from a new safety_max: max - ceil(max/10)
  logic [16:0]        max_plus9;
  logic [36:0]        tenth_prod;
  logic [13:0]        ceil_tenth;

  assign max_plus9  = {1'b0, cfg_data} + 17'd9;
  assign tenth_prod = 37'(max_plus9) * 37'(RECIP_TENTH);
  assign ceil_tenth = tenth_prod[RECIP_SHIFT +: 14];

  assign cfg_ready = 1'b1;

  // Handshake: the word in the input register moves on when the output is free
  assign advance  = in_full && (!out_valid || !out_stall);
  assign in_stall = in_full && out_valid && out_stall;
  assign in_take  = in_valid && !in_stall;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      setpoint_temp    <= '0;
      low_warn_offset  <= '0;
      low_ok_offset    <= '0;
      high_ok_offset   <= '0;
      high_warn_offset <= '0;
      safety_max       <= SAFETY_MAX_RESET;
      safety_lower     <= SAFETY_LOWER_RESET;
      sensors_in_use   <= '0;
      unconnected_mark <= UNCONNECTED_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SETPOINT:    setpoint_temp    <= cfg_data[14:0];
        CFG_LOW_WARN:    low_warn_offset  <= cfg_data;
        CFG_LOW_OK:      low_ok_offset    <= cfg_data;
        CFG_HIGH_OK:     high_ok_offset   <= cfg_data;
        CFG_HIGH_WARN:   high_warn_offset <= cfg_data;
        CFG_SAFETY_MAX: begin
          safety_max   <= cfg_data;
          safety_lower <= cfg_data - {2'b00, ceil_tenth};
        end
        CFG_SENSORS:     sensors_in_use   <= cfg_data[2:0];
        CFG_UNCONNECTED: unconnected_mark <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else begin
      in_full <= in_take || (in_full && !advance);
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item_opcode     <= opcode;
      item_zone_temp  <= zone_temp;
      item_pid_drive  <= pid_drive;
      item_seq_number <= seq_number;
      item_sensor[0]  <= safety_temp_a;
      item_sensor[1]  <= safety_temp_b;
      item_sensor[2]  <= safety_temp_c;
      item_sensor[3]  <= safety_temp_d;
    end
  end

  // Safety sensor scan: trip at max, release when all examined are below the lower level
  always_comb begin
    sensors_eff = (sensors_in_use > 3'(SENSOR_LIMIT)) ? 3'(SENSOR_LIMIT) : sensors_in_use;
    trip        = 1'b0;
    release_ok  = 1'b1;
    sensor_val  = '0;
    for (int i = 0; i < NUM_SENSOR_FIELDS; i++) begin
      if (3'(i) < sensors_eff) begin
        sensor_val = (item_sensor[i] >= unconnected_mark) ? 16'd0 : item_sensor[i];
        if (sensor_val >= safety_max) trip = 1'b1;
        if (sensor_val >= safety_lower) release_ok = 1'b0;
      end
    end
  end

  // Window checks against the latched bounds
  assign temp_ext       = {{2{item_zone_temp[15]}}, item_zone_temp};
  assign setpoint_ext   = {3'b000, setpoint_temp};
  assign in_ok_window   = (temp_ext >= bound_low_ok) && (temp_ext <= bound_high_ok);
  assign in_warn_window = (temp_ext >= bound_low_warn) && (temp_ext <= bound_high_warn);

  // Command execution
  always_comb begin
    mode_next             = mode;
    bound_low_warn_next   = bound_low_warn;
    bound_low_ok_next     = bound_low_ok;
    bound_high_ok_next    = bound_high_ok;
    bound_high_warn_next  = bound_high_warn;
    stored_seq_next       = stored_seq;
    setpoint_applied_next = setpoint_applied;
    safety_latched_next   = safety_latched;
    error_flag_next       = error_flag;
    warning_flag_next     = warning_flag;
    power_valid_next      = 1'b0;
    output_power_next     = '0;
    seq_done_next         = 1'b0;
    done_seq_number_next  = '0;
    accepted_next         = 1'b0;

    case (item_opcode)
      OP_ENABLE: begin
        mode_next = MODE_STANDBY;
      end
      OP_DISABLE: begin
        mode_next        = MODE_OFF;
        power_valid_next = 1'b1;
      end
      OP_APPLY: begin
        // Bounds are latched even while off
        bound_low_warn_next  = setpoint_ext + {{2{low_warn_offset[15]}}, low_warn_offset};
        bound_low_ok_next    = setpoint_ext + {{2{low_ok_offset[15]}}, low_ok_offset};
        bound_high_ok_next   = setpoint_ext + {{2{high_ok_offset[15]}}, high_ok_offset};
        bound_high_warn_next = setpoint_ext + {{2{high_warn_offset[15]}}, high_warn_offset};
        if (mode != MODE_OFF) begin
          setpoint_applied_next = 1'b1;
          stored_seq_next       = item_seq_number;
          mode_next             = MODE_MOVING;
          accepted_next         = 1'b1;
        end
      end
      OP_SAMPLE: begin
        if (mode == MODE_MOVING) begin
          if (in_ok_window) begin
            mode_next = MODE_READY;
            if (setpoint_applied && (stored_seq != 32'd0)) begin
              seq_done_next        = 1'b1;
              done_seq_number_next = stored_seq;
            end
          end
        end else if (mode == MODE_READY) begin
          if (!in_warn_window) begin
            error_flag_next = 1'b1;
          end else begin
            error_flag_next   = 1'b0;
            warning_flag_next = !in_ok_window;
          end
        end
        // Moving or ready: safety check and gated drive
        if (mode == MODE_MOVING || mode == MODE_READY) begin
          if (trip) safety_latched_next = 1'b1;
          if (release_ok) safety_latched_next = 1'b0;
          power_valid_next  = 1'b1;
          output_power_next = safety_latched_next ? 16'd0 : item_pid_drive;
        end
      end
      default: ;
    endcase
  end

  // Zone state update
  always_ff @(posedge clk) begin
    if (rst) begin
      mode             <= MODE_OFF;
      bound_low_warn   <= '0;
      bound_low_ok     <= '0;
      bound_high_ok    <= '0;
      bound_high_warn  <= '0;
      stored_seq       <= '0;
      setpoint_applied <= 1'b0;
      safety_latched   <= 1'b0;
      error_flag       <= 1'b0;
      warning_flag     <= 1'b0;
    end else if (advance) begin
      mode             <= mode_next;
      bound_low_warn   <= bound_low_warn_next;
      bound_low_ok     <= bound_low_ok_next;
      bound_high_ok    <= bound_high_ok_next;
      bound_high_warn  <= bound_high_warn_next;
      stored_seq       <= stored_seq_next;
      setpoint_applied <= setpoint_applied_next;
      safety_latched   <= safety_latched_next;
      error_flag       <= error_flag_next;
      warning_flag     <= warning_flag_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= advance || (out_valid && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      zone_mode       <= mode_next;
      power_valid     <= power_valid_next;
      output_power    <= output_power_next;
      temp_error      <= error_flag_next;
      temp_warning    <= warning_flag_next;
      safety_error    <= safety_latched_next;
      seq_done        <= seq_done_next;
      done_seq_number <= done_seq_number_next;
      accepted        <= accepted_next;
    end
  end

`ifndef SYNTH
  // Input side only stalls behind a full, stalled output word
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a blocked output word");

  // Drive is gated to zero whenever the safety latch is set
  a_power_gated: assert property (@(posedge clk) disable iff (rst)
    (out_valid && safety_error) |-> (output_power == 16'd0))
    else $error("power driven while safety latched");

  // Completion notice only on reaching ready, with a nonzero number
  a_done_ready: assert property (@(posedge clk) disable iff (rst)
    (out_valid && seq_done) |-> (zone_mode == MODE_READY && done_seq_number != 32'd0))
    else $error("completion notice outside ready");

  // An accepted apply always leaves the zone moving
  a_accept_moving: assert property (@(posedge clk) disable iff (rst)
    (out_valid && accepted) |-> (zone_mode == MODE_MOVING))
    else $error("apply accepted but zone not moving");

  // A completed word leaves the input register for the output in the next cycle
  a_advance: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("advanced word lost");
`endif

endmodule
